// File: sv/smm_pkg.sv
package smm_pkg;

	// Q16.16 data words
	localparam int DATA_W          = 32;
	localparam int FRAC_W          = 16;
	localparam int PROD_W          = 2 * DATA_W;
	localparam int MAT_DIM_DEFAULT = 4;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_RUN,
		ST_DRAIN
	} smm_state_t;

	// controller -> datapath, one MAC issue per cycle in ST_RUN
	typedef struct packed {
		logic wr_en;      // store the accepted transaction
		logic issue;      // read operands for one multiply-accumulate step
		logic first_k;    // first step of an output element: seed with C
		logic last_k;     // last step of an output element: emit result
		logic last_elem;  // last output element of the job
	} smm_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic v_s1;
		logic v_s2;
	} smm_status_t;

endpackage

// File: sv/smm_ram.sv
module smm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/smm_ctrl.sv
module smm_ctrl #(
	parameter int MAT_DIM = smm_pkg::MAT_DIM_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        last_in,
	output logic                        busy,
	output smm_pkg::smm_cmd_t           cmd,
	input  smm_pkg::smm_status_t        status,
	output logic [((MAT_DIM*MAT_DIM > 1) ? $clog2(MAT_DIM*MAT_DIM) : 1)-1:0] wr_addr,
	output logic [((MAT_DIM*MAT_DIM > 1) ? $clog2(MAT_DIM*MAT_DIM) : 1)-1:0] a_addr,
	output logic [((MAT_DIM*MAT_DIM > 1) ? $clog2(MAT_DIM*MAT_DIM) : 1)-1:0] b_addr,
	output logic [((MAT_DIM*MAT_DIM > 1) ? $clog2(MAT_DIM*MAT_DIM) : 1)-1:0] c_addr
);

	import smm_pkg::*;

	localparam int ELEMS = MAT_DIM * MAT_DIM;
	localparam int IDX_W = (ELEMS > 1) ? $clog2(ELEMS) : 1;
	localparam int DIM_W = (MAT_DIM > 1) ? $clog2(MAT_DIM) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ELEMS - 1);
	localparam logic [DIM_W-1:0] DIM_LAST = DIM_W'(MAT_DIM - 1);
	localparam logic [IDX_W-1:0] DIM_IDX  = IDX_W'(MAT_DIM);

	smm_state_t       state_q, state_d;
	logic [IDX_W-1:0] load_idx_q;
	logic [DIM_W-1:0] r_q, c_q, k_q;
	logic             accept, complete, k_end, c_end, r_end;

	assign accept   = start && (state_q == ST_LOAD);
	assign complete = accept && (last_in || (load_idx_q == IDX_LAST));
	assign k_end    = (k_q == DIM_LAST);
	assign c_end    = (c_q == DIM_LAST);
	assign r_end    = (r_q == DIM_LAST);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (complete) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (k_end && c_end && r_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.v_s1 && !status.v_s2) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		busy      = 1'b1;
		case (state_q)
			ST_LOAD: begin
				busy       = 1'b0;
				cmd.wr_en  = start;
			end
			ST_RUN: begin
				cmd.issue     = 1'b1;
				cmd.first_k   = (k_q == '0);
				cmd.last_k    = k_end;
				cmd.last_elem = k_end && c_end && r_end;
			end
			ST_DRAIN: begin
				busy = 1'b1;
			end
			default: busy = 1'b1;
		endcase
	end

	assign wr_addr = load_idx_q;
	assign a_addr  = IDX_W'(r_q) * DIM_IDX + IDX_W'(k_q);
	assign b_addr  = IDX_W'(k_q) * DIM_IDX + IDX_W'(c_q);
	assign c_addr  = IDX_W'(r_q) * DIM_IDX + IDX_W'(c_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			load_idx_q <= '0;
			r_q        <= '0;
			c_q        <= '0;
			k_q        <= '0;
		end else begin
			state_q <= state_d;
			if (complete) begin
				load_idx_q <= '0;
				r_q        <= '0;
				c_q        <= '0;
				k_q        <= '0;
			end else if (accept) begin
				load_idx_q <= load_idx_q + IDX_W'(1);
			end
			if (state_q == ST_RUN) begin
				// k innermost, then column, then row
				k_q <= k_end ? '0 : k_q + DIM_W'(1);
				if (k_end) begin
					c_q <= c_end ? '0 : c_q + DIM_W'(1);
					if (c_end) begin
						r_q <= r_end ? '0 : r_q + DIM_W'(1);
					end
				end
			end
		end
	end

endmodule

// File: sv/smm_datapath.sv
module smm_datapath #(
	parameter int MAT_DIM = smm_pkg::MAT_DIM_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  smm_pkg::smm_cmd_t           cmd,
	output smm_pkg::smm_status_t        status,
	input  logic [((MAT_DIM*MAT_DIM > 1) ? $clog2(MAT_DIM*MAT_DIM) : 1)-1:0] wr_addr,
	input  logic [((MAT_DIM*MAT_DIM > 1) ? $clog2(MAT_DIM*MAT_DIM) : 1)-1:0] a_addr,
	input  logic [((MAT_DIM*MAT_DIM > 1) ? $clog2(MAT_DIM*MAT_DIM) : 1)-1:0] b_addr,
	input  logic [((MAT_DIM*MAT_DIM > 1) ? $clog2(MAT_DIM*MAT_DIM) : 1)-1:0] c_addr,
	input  logic signed [smm_pkg::DATA_W-1:0] a_elem,
	input  logic signed [smm_pkg::DATA_W-1:0] b_elem,
	input  logic signed [smm_pkg::DATA_W-1:0] c_elem,
	output logic                        out_valid,
	output logic signed [smm_pkg::DATA_W-1:0] c_out,
	output logic                        last_out
);

	import smm_pkg::*;

	localparam int ELEMS  = MAT_DIM * MAT_DIM;
	localparam int TERM_W = PROD_W - FRAC_W;
	// products after the floor shift, summed N times plus C
	localparam int ACC_W  = TERM_W + $clog2(MAT_DIM + 1);
	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'({1'b0, {(DATA_W-1){1'b1}}});
	localparam logic signed [ACC_W-1:0] SAT_MIN =
		{{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

	logic [DATA_W-1:0]        a_rd, b_rd, c_rd;
	logic                     v_s1, first_s1, last_k_s1, last_e_s1;
	logic                     v_s2, first_s2, last_k_s2, last_e_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [DATA_W-1:0] c_init_s2;
	logic signed [ACC_W-1:0]  acc_q, term, base, sum;
	logic signed [DATA_W-1:0] sat;
	logic                     out_v_q, out_last_q;
	logic signed [DATA_W-1:0] out_q;

	smm_ram #(.WIDTH(DATA_W), .DEPTH(ELEMS)) u_a_ram (
		.clk(clk), .we(cmd.wr_en), .waddr(wr_addr), .wdata(a_elem),
		.raddr(a_addr), .rdata(a_rd)
	);
	smm_ram #(.WIDTH(DATA_W), .DEPTH(ELEMS)) u_b_ram (
		.clk(clk), .we(cmd.wr_en), .waddr(wr_addr), .wdata(b_elem),
		.raddr(b_addr), .rdata(b_rd)
	);
	smm_ram #(.WIDTH(DATA_W), .DEPTH(ELEMS)) u_c_ram (
		.clk(clk), .we(cmd.wr_en), .waddr(wr_addr), .wdata(c_elem),
		.raddr(c_addr), .rdata(c_rd)
	);

	// stage 2: floor(product / 2^16) is the arithmetic shift
	assign term = {{(ACC_W-TERM_W){prod_s2[PROD_W-1]}}, prod_s2[PROD_W-1:FRAC_W]};
	assign base = first_s2 ? {{(ACC_W-DATA_W){c_init_s2[DATA_W-1]}}, c_init_s2} : acc_q;
	assign sum  = base + term;

	always_comb begin
		if (sum > SAT_MAX) begin
			sat = SAT_MAX[DATA_W-1:0];
		end else if (sum < SAT_MIN) begin
			sat = SAT_MIN[DATA_W-1:0];
		end else begin
			sat = sum[DATA_W-1:0];
		end
	end

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			v_s1    <= cmd.issue;
			v_s2    <= v_s1;
			out_v_q <= v_s2 && last_k_s2;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		first_s1  <= cmd.first_k;
		last_k_s1 <= cmd.last_k;
		last_e_s1 <= cmd.last_elem;
		first_s2  <= first_s1;
		last_k_s2 <= last_k_s1;
		last_e_s2 <= last_e_s1;
		prod_s2   <= PROD_W'(signed'(a_rd)) * PROD_W'(signed'(b_rd));
		if (first_s1) begin
			c_init_s2 <= signed'(c_rd);
		end
		if (v_s2) begin
			acc_q <= sum;
		end
		if (v_s2 && last_k_s2) begin
			out_q      <= sat;
			out_last_q <= last_e_s2;
		end
	end

	assign status.v_s1 = v_s1;
	assign status.v_s2 = v_s2;
	assign out_valid   = out_v_q;
	assign c_out       = out_q;
	assign last_out    = out_v_q && out_last_q;

endmodule

// File: sv/small_matrix_multiply_accumulate.sv
// Load: one transaction per cycle while busy is low; each writes one A, B and C element.
// After the job's final transaction, one shared multiply-accumulate unit runs the job
// (one step per cycle), and each result element is output after its last step.
// busy stays high through compute and drops after the final result strobe.
// Results strobe out_valid for one cycle each; the receiver cannot stall them.
// arst_n (async, active low) clears control state; stored matrices are not cleared.
module small_matrix_multiply_accumulate #(
	parameter int MAT_DIM = smm_pkg::MAT_DIM_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [smm_pkg::DATA_W-1:0] a_elem,
	input  logic signed [smm_pkg::DATA_W-1:0] b_elem,
	input  logic signed [smm_pkg::DATA_W-1:0] c_elem,
	input  logic                              last_in,
	output logic                              out_valid,
	output logic signed [smm_pkg::DATA_W-1:0] c_out,
	output logic                              last_out
);

	import smm_pkg::*;

	localparam int ELEMS = MAT_DIM * MAT_DIM;
	localparam int IDX_W = (ELEMS > 1) ? $clog2(ELEMS) : 1;

	// Controller walks load index during load, then r/c/k counters during compute.
	// A transaction completes a job on last_in or on the N*N-th element.
	smm_cmd_t         cmd;
	smm_status_t      status;
	logic [IDX_W-1:0] wr_addr, a_addr, b_addr, c_addr;

	smm_ctrl #(.MAT_DIM(MAT_DIM)) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.last_in (last_in),
		.busy    (busy),
		.cmd     (cmd),
		.status  (status),
		.wr_addr (wr_addr),
		.a_addr  (a_addr),
		.b_addr  (b_addr),
		.c_addr  (c_addr)
	);

	// Datapath: three operand RAMs (registered read), 32x32 multiply into
	// the s2 register, floor shift + wide accumulate, saturate into the
	// output register. Element positions not loaded in a short job keep
	// their earlier contents.
	smm_datapath #(.MAT_DIM(MAT_DIM)) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.wr_addr   (wr_addr),
		.a_addr    (a_addr),
		.b_addr    (b_addr),
		.c_addr    (c_addr),
		.a_elem    (a_elem),
		.b_elem    (b_elem),
		.c_elem    (c_elem),
		.out_valid (out_valid),
		.c_out     (c_out),
		.last_out  (last_out)
	);

endmodule

// File: sv/smm_checker.sv
module smm_sva (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic last_in,
	input logic out_valid,
	input logic last_out
);

	// results only come out of a running job
	a_strobe_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $past(busy))
		else $error("result strobe outside a job");

	// a marked last transaction starts the compute phase
	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_in) |=> busy)
		else $error("job did not start after last transaction");

	// nothing follows the final result directly
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_out) |=> !out_valid)
		else $error("result right after final result");

	// busy drops only after the final result
	a_busy_release: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(out_valid && last_out))
		else $error("busy released before final result");

endmodule

bind small_matrix_multiply_accumulate smm_sva u_smm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.last_in   (last_in),
	.out_valid (out_valid),
	.last_out  (last_out)
);
